/* rtl/core/ring_election_token_node_macros.svh */
// Assertion macros used by the ring node top module.
`ifndef RING_ELECTION_TOKEN_NODE_MACROS_SVH
`define RING_ELECTION_TOKEN_NODE_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define RETN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define RETN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/retn_pkg.sv */
package retn_pkg;

    localparam int ID_FIELD_W    = 8;
    localparam int STAMP_W       = 27;
    localparam int ID_BITS_DEF   = 8;

    typedef enum logic [3:0] {
        EV_RING     = 4'd0,
        EV_ELECTION = 4'd1,
        EV_ELECTED  = 4'd2,
        EV_CLEAR    = 4'd3,
        EV_MARKER   = 4'd4,
        EV_LINKUP   = 4'd5,
        EV_ENTER    = 4'd6,
        EV_RELEASE  = 4'd7,
        EV_RETRY    = 4'd8
    } event_kind_t;

    typedef enum logic [2:0] {
        MSG_RING      = 3'd0,
        MSG_CANDIDATE = 3'd1,
        MSG_LEADER    = 3'd2,
        MSG_CLEAR     = 3'd3,
        MSG_MARKER    = 3'd4
    } msg_kind_t;

    typedef enum logic [1:0] {
        A_INIT     = 2'd0,
        A_RELEASED = 2'd1,
        A_WANTED   = 2'd2,
        A_HELD     = 2'd3
    } access_t;

    typedef struct packed {
        event_kind_t             kind;
        logic [ID_FIELD_W-1:0]   msg_id;
        logic [STAMP_W-1:0]      msg_stamp;
        logic [STAMP_W-1:0]      now_stamp;
    } item_t;

    typedef struct packed {
        logic                    valid;
        msg_kind_t               kind;
        logic [ID_FIELD_W-1:0]   id;
        logic [STAMP_W-1:0]      stamp;
    } msg_t;

    typedef struct packed {
        logic                    ring_up;
        logic [ID_FIELD_W-1:0]   coord_id;
        logic                    coord_known;
        access_t                 access;
        logic                    marking;
    } status_t;

    typedef struct packed {
        msg_t                    msg0;
        msg_t                    msg1;
        status_t                 status;
    } bundle_t;

    function automatic msg_t make_msg(msg_kind_t k, logic [ID_FIELD_W-1:0] id,
                                      logic [STAMP_W-1:0] st);
        msg_t m;
        m.valid = 1'b1;
        m.kind  = k;
        m.id    = id;
        m.stamp = st;
        return m;
    endfunction

endpackage

/* rtl/core/ring_election_token_node.sv */
// Channel   Direction  Handshake               Payload
// s_        in         s_tvalid / s_tready     s_tuser event kind, s_tdata message fields
// m_        out        m_tvalid / m_tready     m_tuser send flag and kind, m_tdata, m_tlast
// cfg_      in         cfg_valid / cfg_ready   cfg_data own id
//
// An accepted item is decided once the output bundle register is free and yields one or two results.
// Items with one result sustain one per cycle while m_tready is high; two results leave in order.
// The output bundle register sets the rate: it reloads only when empty or as its last result leaves.
// Reset is synchronous and active low; it clears node state, the own id and both valid flags.
// A stalled output holds its result and backs up into the input register and s_tready.
// The own id is taken only while no item waits in the input register.
`include "ring_election_token_node_macros.svh"

module ring_election_token_node
    import retn_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // msg_id[7:0], msg_stamp[34:8], now_stamp[61:35], zero
    input  logic [3:0]  s_tuser,   // event_kind[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // send_id[7:0], send_stamp[34:8], ring_up[35],
                                   // coordinator_id[43:36], coordinator_known[44],
                                   // access_state[46:45], marking[47]
    output logic [3:0]  m_tuser,   // send_valid[0], send_kind[3:1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic                  in_valid_reg;
    item_t                 item_reg;
    logic [ID_FIELD_W-1:0] own_id_reg;
    logic                  fire;
    logic                  out_free;
    bundle_t               step_bundle;
    msg_t                  cur_msg;
    status_t               cur_status;

    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = !in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            own_id_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                own_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind      <= event_kind_t'(s_tuser);
            item_reg.msg_id    <= s_tdata[7:0];
            item_reg.msg_stamp <= s_tdata[34:8];
            item_reg.now_stamp <= s_tdata[61:35];
        end
    end

    retn_step #(
        .ID_BITS (ID_BITS)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .own_id  (own_id_reg),
        .result  (step_bundle)
    );

    retn_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .bundle_in  (step_bundle),
        .m_tready   (m_tready),
        .free       (out_free),
        .m_tvalid   (m_tvalid),
        .m_tlast    (m_tlast),
        .cur_msg    (cur_msg),
        .cur_status (cur_status)
    );

    assign m_tuser = {cur_msg.kind, cur_msg.valid};
    assign m_tdata = {cur_status.marking, cur_status.access, cur_status.coord_known,
                      cur_status.coord_id, cur_status.ring_up, cur_msg.stamp, cur_msg.id};

    `RETN_ASSERT_NOW(a_empty_single, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast,
        "result without a message is not the last of its item")
    `RETN_ASSERT_NEXT(a_second_follows, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tlast && m_tuser[0], "second result of an item did not follow")
    `RETN_ASSERT_NOW(a_coord_zero, aclk, aresetn, m_tvalid && !m_tdata[44],
        m_tdata[43:36] == 8'd0, "coordinator id shown while not known")
    `RETN_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_tready, in_valid_reg && m_tvalid,
        "input stalled with room in the pipeline")

endmodule

/* rtl/core/retn_step.sv */
module retn_step
    import retn_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  item_t                 item,
    input  logic [ID_FIELD_W-1:0] own_id,
    output bundle_t               result
);

    localparam int ID_W = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;

    logic               participant_reg, participant_next;
    logic [ID_W-1:0]    coord_reg, coord_next;
    logic               coord_valid_reg, coord_valid_next;
    logic               ring_up_reg, ring_up_next;
    access_t            access_reg, access_next;
    logic               marking_reg, marking_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               clear_pending_reg, clear_pending_next;

    logic [ID_W-1:0]       me, mid;
    logic [ID_FIELD_W-1:0] me_ext, mid_ext;
    logic                  is_coord;
    msg_t                  m0, m1;

    assign me       = own_id[ID_W-1:0];
    assign mid      = item.msg_id[ID_W-1:0];
    assign me_ext   = ID_FIELD_W'(me);
    assign mid_ext  = ID_FIELD_W'(mid);
    assign is_coord = coord_valid_reg && (coord_reg == me);

    always_comb begin
        participant_next   = participant_reg;
        coord_next         = coord_reg;
        coord_valid_next   = coord_valid_reg;
        ring_up_next       = ring_up_reg;
        access_next        = access_reg;
        marking_next       = marking_reg;
        stamp_next         = stamp_reg;
        clear_pending_next = clear_pending_reg;
        m0 = '0;
        m1 = '0;
        case (item.kind)
            EV_RING: begin
                if (mid == me) begin
                    ring_up_next     = 1'b1;
                    coord_valid_next = 1'b0;
                    coord_next       = '0;
                    participant_next = 1'b1;
                    m0 = make_msg(MSG_CANDIDATE, me_ext, '0);
                end else begin
                    m0 = make_msg(MSG_RING, mid_ext, '0);
                end
            end
            EV_ELECTION: begin
                if (mid > me) begin
                    coord_valid_next = 1'b0;
                    coord_next       = '0;
                    participant_next = 1'b1;
                    m0 = make_msg(MSG_CANDIDATE, mid_ext, '0);
                end else if (mid < me) begin
                    if (!participant_reg) begin
                        coord_valid_next = 1'b0;
                        coord_next       = '0;
                        participant_next = 1'b1;
                        m0 = make_msg(MSG_CANDIDATE, me_ext, '0);
                    end
                end else begin
                    coord_next       = me;
                    coord_valid_next = 1'b1;
                    participant_next = 1'b0;
                    m0 = make_msg(MSG_LEADER, me_ext, '0);
                end
            end
            EV_ELECTED: begin
                if (access_reg == A_INIT) begin
                    access_next = A_RELEASED;
                end
                if (mid != me) begin
                    coord_next       = mid;
                    coord_valid_next = 1'b1;
                    participant_next = 1'b0;
                    m0 = make_msg(MSG_LEADER, mid_ext, '0);
                end else if (is_coord) begin
                    marking_next = 1'b1;
                    stamp_next   = '0;
                    m0 = make_msg(MSG_CLEAR, '0, '0);
                end
            end
            EV_CLEAR: begin
                if (access_reg != A_HELD) begin
                    if (is_coord) begin
                        stamp_next = item.now_stamp;
                        m0 = make_msg(MSG_MARKER, '0, item.now_stamp);
                    end else begin
                        marking_next = 1'b1;
                        stamp_next   = '0;
                        m0 = make_msg(MSG_CLEAR, '0, '0);
                    end
                end else begin
                    clear_pending_next = 1'b1;
                end
            end
            EV_MARKER: begin
                if (marking_reg) begin
                    if (is_coord) begin
                        if (stamp_reg == item.msg_stamp) begin
                            marking_next = 1'b0;
                            m0 = make_msg(MSG_MARKER, '0, item.msg_stamp);
                        end
                    end else if (stamp_reg == '0) begin
                        marking_next = 1'b0;
                        stamp_next   = item.msg_stamp;
                        m0 = make_msg(MSG_MARKER, '0, item.msg_stamp);
                    end else if (stamp_reg == item.msg_stamp) begin
                        m0 = make_msg(MSG_MARKER, '0, item.msg_stamp);
                    end
                end else if (access_reg == A_WANTED && stamp_reg != '0) begin
                    access_next = A_HELD;
                end else if (access_reg == A_RELEASED) begin
                    m0 = make_msg(MSG_MARKER, '0, item.msg_stamp);
                end
            end
            EV_LINKUP: begin
                ring_up_next = 1'b0;
                m0 = make_msg(MSG_RING, me_ext, '0);
            end
            EV_ENTER: begin
                if (access_reg == A_RELEASED && stamp_reg != '0) begin
                    access_next = A_WANTED;
                end
            end
            EV_RELEASE: begin
                if (access_reg == A_HELD) begin
                    access_next = A_RELEASED;
                    m0 = make_msg(MSG_MARKER, '0, stamp_reg);
                    if (clear_pending_reg) begin
                        clear_pending_next = 1'b0;
                        if (is_coord) begin
                            stamp_next = item.now_stamp;
                            m1 = make_msg(MSG_MARKER, '0, item.now_stamp);
                        end else begin
                            marking_next = 1'b1;
                            stamp_next   = '0;
                            m1 = make_msg(MSG_CLEAR, '0, '0);
                        end
                    end
                end
            end
            EV_RETRY: begin
                if (!ring_up_reg) begin
                    m0 = make_msg(MSG_RING, me_ext, '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.msg0                = m0;
        result.msg1                = m1;
        result.status.ring_up      = ring_up_next;
        result.status.coord_id     = coord_valid_next ? ID_FIELD_W'(coord_next) : '0;
        result.status.coord_known  = coord_valid_next;
        result.status.access       = access_next;
        result.status.marking      = marking_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            participant_reg   <= 1'b0;
            coord_reg         <= '0;
            coord_valid_reg   <= 1'b0;
            ring_up_reg       <= 1'b0;
            access_reg        <= A_INIT;
            marking_reg       <= 1'b0;
            stamp_reg         <= '0;
            clear_pending_reg <= 1'b0;
        end else if (fire) begin
            participant_reg   <= participant_next;
            coord_reg         <= coord_next;
            coord_valid_reg   <= coord_valid_next;
            ring_up_reg       <= ring_up_next;
            access_reg        <= access_next;
            marking_reg       <= marking_next;
            stamp_reg         <= stamp_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

endmodule

/* rtl/core/retn_outbuf.sv */
module retn_outbuf
    import retn_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  bundle_t bundle_in,
    input  logic    m_tready,
    output logic    free,
    output logic    m_tvalid,
    output logic    m_tlast,
    output msg_t    cur_msg,
    output status_t cur_status
);

    logic    valid_reg;
    logic    sel_reg;
    bundle_t bundle_reg;

    assign m_tvalid   = valid_reg;
    assign m_tlast    = !bundle_reg.msg1.valid || sel_reg;
    assign cur_msg    = sel_reg ? bundle_reg.msg1 : bundle_reg.msg0;
    assign cur_status = bundle_reg.status;
    assign free       = !valid_reg || (m_tready && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end else if (valid_reg && m_tready) begin
            if (m_tlast) begin
                valid_reg <= 1'b0;
            end else begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle_in;
        end
    end

endmodule

/* tb/ring_node_checker.sv */
module ring_node_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          error_count,
    output int          results_left,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import retn_pkg::*;

    localparam logic [7:0] ID_MASK = 8'((64'd1 << ID_BITS_DEF) - 64'd1);

    typedef struct packed {
        logic        send_valid;
        msg_kind_t   send_kind;
        logic [7:0]  send_id;
        logic [26:0] send_stamp;
        logic        last;
        logic        ring_up;
        logic [7:0]  coord_id;
        logic        coord_known;
        access_t     access;
        logic        marking;
    } node_result_t;

    node_result_t due_results[$];
    int mismatches = 0;
    int checked = 0;

    logic [7:0]  own_id_q;
    logic        participant_q;
    logic [7:0]  coord_id_q;
    logic        coord_known_q;
    logic        ring_up_q;
    access_t     access_q;
    logic        marking_q;
    logic [26:0] stamp_q;
    logic        clear_pending_q;

    msg_kind_t   out_kind[2];
    logic [7:0]  out_id[2];
    logic [26:0] out_stamp[2];
    int          out_n;

    assign error_count  = mismatches;
    assign results_seen = checked;

    function automatic logic [7:0] my_id();
        return own_id_q & ID_MASK;
    endfunction

    function automatic logic is_coordinator();
        return coord_known_q && coord_id_q == my_id();
    endfunction

    function automatic string show(node_result_t r);
        return $sformatf({"valid=%0d kind=%0d id=%0d stamp=%0d last=%0d ring_up=%0d ",
                          "coord=%0d known=%0d access=%0d marking=%0d"},
                         r.send_valid, r.send_kind, r.send_id, r.send_stamp, r.last,
                         r.ring_up, r.coord_id, r.coord_known, r.access, r.marking);
    endfunction

    task automatic queue_msg(input msg_kind_t kind, input logic [7:0] id,
                             input logic [26:0] stamp);
        if (out_n < 2) begin
            out_kind[out_n]  = kind;
            out_id[out_n]    = id;
            out_stamp[out_n] = stamp;
            out_n++;
        end
    endtask

    task automatic begin_election();
        coord_known_q = 1'b0;
        coord_id_q    = '0;
        participant_q = 1'b1;
        queue_msg(MSG_CANDIDATE, my_id(), '0);
    endtask

    task automatic take_clear(input logic [26:0] now);
        if (is_coordinator()) begin
            stamp_q = now;
            queue_msg(MSG_MARKER, '0, stamp_q);
        end else begin
            marking_q = 1'b1;
            stamp_q   = '0;
            queue_msg(MSG_CLEAR, '0, '0);
        end
    endtask

    task automatic advance_node(input logic [3:0] kind, input logic [7:0] id_in,
                                input logic [26:0] mst, input logic [26:0] now);
        node_result_t r;
        logic [7:0] mid;
        int n;
        mid = id_in & ID_MASK;
        out_n = 0;
        case (kind)
            EV_RING: begin
                if (mid == my_id()) begin
                    ring_up_q = 1'b1;
                    begin_election();
                end else begin
                    queue_msg(MSG_RING, mid, '0);
                end
            end
            EV_ELECTION: begin
                if (mid > my_id()) begin
                    coord_known_q = 1'b0;
                    coord_id_q    = '0;
                    participant_q = 1'b1;
                    queue_msg(MSG_CANDIDATE, mid, '0);
                end else if (mid < my_id()) begin
                    if (!participant_q) begin
                        begin_election();
                    end
                end else begin
                    coord_id_q    = my_id();
                    coord_known_q = 1'b1;
                    participant_q = 1'b0;
                    queue_msg(MSG_LEADER, my_id(), '0);
                end
            end
            EV_ELECTED: begin
                if (mid != my_id()) begin
                    coord_id_q    = mid;
                    coord_known_q = 1'b1;
                    participant_q = 1'b0;
                    queue_msg(MSG_LEADER, mid, '0);
                end
                if (access_q == A_INIT) begin
                    access_q = A_RELEASED;
                end
                if (is_coordinator()) begin
                    marking_q = 1'b1;
                    stamp_q   = '0;
                    queue_msg(MSG_CLEAR, '0, '0);
                end
            end
            EV_CLEAR: begin
                if (access_q != A_HELD) begin
                    take_clear(now);
                end else begin
                    clear_pending_q = 1'b1;
                end
            end
            EV_MARKER: begin
                if (marking_q) begin
                    if (is_coordinator()) begin
                        if (stamp_q == mst) begin
                            marking_q = 1'b0;
                            queue_msg(MSG_MARKER, '0, mst);
                        end
                    end else if (stamp_q == '0) begin
                        marking_q = 1'b0;
                        stamp_q   = mst;
                        queue_msg(MSG_MARKER, '0, mst);
                    end else if (stamp_q == mst) begin
                        queue_msg(MSG_MARKER, '0, mst);
                    end
                end else if (access_q == A_WANTED && stamp_q != '0) begin
                    access_q = A_HELD;
                end else if (access_q == A_RELEASED) begin
                    queue_msg(MSG_MARKER, '0, mst);
                end
            end
            EV_LINKUP: begin
                ring_up_q = 1'b0;
                queue_msg(MSG_RING, my_id(), '0);
            end
            EV_ENTER: begin
                if (access_q == A_RELEASED && stamp_q != '0) begin
                    access_q = A_WANTED;
                end
            end
            EV_RELEASE: begin
                if (access_q == A_HELD) begin
                    access_q = A_RELEASED;
                    queue_msg(MSG_MARKER, '0, stamp_q);
                    if (clear_pending_q) begin
                        take_clear(now);
                        clear_pending_q = 1'b0;
                    end
                end
            end
            EV_RETRY: begin
                if (!ring_up_q) begin
                    queue_msg(MSG_RING, my_id(), '0);
                end
            end
            default: begin
            end
        endcase

        n = (out_n == 0) ? 1 : out_n;
        for (int k = 0; k < n; k++) begin
            r.send_valid  = (out_n != 0);
            r.send_kind   = r.send_valid ? out_kind[k] : MSG_RING;
            r.send_id     = r.send_valid ? out_id[k] : '0;
            r.send_stamp  = r.send_valid ? out_stamp[k] : '0;
            r.last        = (k == n - 1);
            r.ring_up     = ring_up_q;
            r.coord_id    = coord_known_q ? coord_id_q : '0;
            r.coord_known = coord_known_q;
            r.access      = access_q;
            r.marking     = marking_q;
            due_results.insert(due_results.size(), r);
        end
    endtask

    task automatic compare_result();
        node_result_t got;
        node_result_t want;
        string bad;
        got.send_valid  = m_tuser[0];
        got.send_kind   = msg_kind_t'(m_tuser[3:1]);
        got.send_id     = m_tdata[7:0];
        got.send_stamp  = m_tdata[34:8];
        got.last        = m_tlast;
        got.ring_up     = m_tdata[35];
        got.coord_id    = m_tdata[43:36];
        got.coord_known = m_tdata[44];
        got.access      = access_t'(m_tdata[46:45]);
        got.marking     = m_tdata[47];
        checked++;
        if (due_results.size() == 0) begin
            if (mismatches < 10) begin
                $display("Unexpected result transaction: %s", show(got));
            end
            mismatches++;
        end else begin
            want = due_results[0];
            due_results.delete(0);
            bad = "";
            if (got.send_valid !== want.send_valid) bad = {bad, " send_valid"};
            if (got.send_kind !== want.send_kind) bad = {bad, " send_kind"};
            if (got.send_id !== want.send_id) bad = {bad, " send_id"};
            if (got.send_stamp !== want.send_stamp) bad = {bad, " send_stamp"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (got.ring_up !== want.ring_up) bad = {bad, " ring_up"};
            if (got.coord_id !== want.coord_id) bad = {bad, " coordinator_id"};
            if (got.coord_known !== want.coord_known) bad = {bad, " coordinator_known"};
            if (got.access !== want.access) bad = {bad, " access_state"};
            if (got.marking !== want.marking) bad = {bad, " marking"};
            if (bad != "") begin
                if (mismatches < 10) begin
                    $display("Result %0d differs in:%s", checked, bad);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            own_id_q        = '0;
            participant_q   = 1'b0;
            coord_id_q      = '0;
            coord_known_q   = 1'b0;
            ring_up_q       = 1'b0;
            access_q        = A_INIT;
            marking_q       = 1'b0;
            stamp_q         = '0;
            clear_pending_q = 1'b0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                compare_result();
            end
            if (cfg_valid && cfg_ready) begin
                own_id_q = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                advance_node(s_tuser, s_tdata[7:0], s_tdata[34:8], s_tdata[61:35]);
            end
        end
        results_left <= due_results.size();
    end

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import retn_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    int error_count;
    int results_left;
    int results_seen;

    int cycle_count = 0;
    int items_sent = 0;
    int config_writes = 0;
    int burst_left = 0;
    int hold_asked = 0;
    int hold_done = 0;
    logic [7:0] own_now = '0;

    ring_election_token_node dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ring_node_checker node_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .results_left (results_left),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles.", CYCLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // The receiver switches between stall patterns and honors long hold-off requests.
    initial begin
        int mode;
        int left;
        int step;
        mode = 0;
        left = 0;
        step = 0;
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_done) begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                step++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (step % 3 != 0);
                endcase
            end
        end
    end

    function automatic logic [26:0] rand_stamp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 27'h7FFFFFF;
            2: return 27'($urandom_range(1, 86399999));
            default: return 27'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_id();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic offer(input logic [3:0] kind, input logic [7:0] id,
                         input logic [26:0] mst, input logic [26:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, now, mst, id};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (results_left != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_own_id(input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        own_now = value;
        config_writes++;
    endtask

    // Request, hold, release, optionally with a clear arriving while the token is held.
    task automatic token_turn(input logic [26:0] s1, input logic [26:0] s2);
        if ($urandom_range(0, 1) == 1) offer(EV_MARKER, rand_id(), s1, rand_stamp());
        offer(EV_ENTER, rand_id(), rand_stamp(), rand_stamp());
        offer(EV_MARKER, rand_id(), rand_stamp(), rand_stamp());
        if ($urandom_range(0, 2) != 0) offer(EV_CLEAR, rand_id(), rand_stamp(), s2);
        offer(EV_RELEASE, rand_id(), rand_stamp(), s2);
        if ($urandom_range(0, 1) == 1) offer(EV_MARKER, rand_id(), s2, rand_stamp());
    endtask

    task automatic run_round();
        logic [7:0] other;
        logic [7:0] pick;
        logic [26:0] s1;
        logic [26:0] s2;
        int n;
        other = rand_id();
        if (other == own_now) other = own_now ^ 8'h01;
        s1 = rand_stamp();
        s2 = rand_stamp();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                offer(EV_LINKUP, rand_id(), rand_stamp(), rand_stamp());
                if ($urandom_range(0, 1) == 1) offer(EV_RETRY, rand_id(), rand_stamp(), s1);
                offer(EV_RING, own_now, rand_stamp(), rand_stamp());
                offer(EV_ELECTION, own_now, rand_stamp(), rand_stamp());
                offer(EV_ELECTED, own_now, rand_stamp(), rand_stamp());
                offer(EV_CLEAR, rand_id(), rand_stamp(), s1);
                if ($urandom_range(0, 1) == 1) begin
                    offer(EV_MARKER, rand_id(), rand_stamp(), rand_stamp());
                end
                offer(EV_MARKER, rand_id(), s1, rand_stamp());
                token_turn(s1, s2);
            end
            3, 4, 5: begin
                offer(EV_ELECTED, other, rand_stamp(), rand_stamp());
                offer(EV_CLEAR, rand_id(), rand_stamp(), rand_stamp());
                if ($urandom_range(0, 2) == 0) begin
                    offer(EV_MARKER, rand_id(), rand_stamp(), rand_stamp());
                end
                offer(EV_MARKER, rand_id(), s1, rand_stamp());
                token_turn(s1, s2);
            end
            6, 7: begin
                n = $urandom_range(2, 6);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: pick = own_now - 8'd1;
                        1: pick = own_now;
                        2: pick = own_now + 8'd1;
                        default: pick = rand_id();
                    endcase
                    case ($urandom_range(0, 2))
                        0: offer(EV_ELECTION, pick, rand_stamp(), rand_stamp());
                        1: offer(EV_RING, pick, rand_stamp(), rand_stamp());
                        default: offer(EV_ELECTED, pick, rand_stamp(), rand_stamp());
                    endcase
                end
            end
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    offer(4'($urandom_range(0, 15)), rand_id(), rand_stamp(), rand_stamp());
                end
            end
        endcase
    endtask

    initial begin
        int target;
        logic [7:0] setting;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Own id 0 from reset: idle behavior, unknown kinds, stray tokens, zero time.
        offer(EV_RETRY, 8'h00, 27'h0, 27'h0);
        offer(4'hF, 8'hFF, 27'h7FFFFFF, 27'h7FFFFFF);
        offer(4'h9, 8'h5A, 27'h2AAAAAA, 27'h5555555);
        offer(EV_MARKER, 8'h00, 27'h1234567, 27'h0);
        offer(EV_ENTER, 8'h00, 27'h0, 27'h0);
        offer(EV_RELEASE, 8'h00, 27'h0, 27'h0);
        offer(EV_LINKUP, 8'hA5, 27'h0, 27'h0);
        offer(EV_RING, 8'h00, 27'h0, 27'h0);
        offer(EV_RETRY, 8'h00, 27'h0, 27'h0);
        offer(EV_ELECTION, 8'hFF, 27'h0, 27'h0);
        offer(EV_ELECTION, 8'h00, 27'h0, 27'h0);
        offer(EV_ELECTED, 8'h00, 27'h0, 27'h0);
        offer(EV_CLEAR, 8'h00, 27'h0, 27'h0);
        offer(EV_MARKER, 8'h00, 27'h0, 27'h0);
        offer(EV_ENTER, 8'h00, 27'h0, 27'h0);
        offer(EV_MARKER, 8'h00, 27'h7FFFFFF, 27'h0);

        // Own id 255: full coordinator cycle with a clear waiting on the release.
        write_own_id(8'hFF);
        offer(EV_ELECTION, 8'h00, 27'h0, 27'h0);
        offer(EV_ELECTION, 8'hFF, 27'h0, 27'h0);
        offer(EV_ELECTED, 8'hFF, 27'h0, 27'h0);
        offer(EV_CLEAR, 8'h00, 27'h0, 27'h7FFFFFF);
        offer(EV_MARKER, 8'h00, 27'h7FFFFFF, 27'h0);
        offer(EV_ENTER, 8'h00, 27'h0, 27'h0);
        offer(EV_MARKER, 8'h00, 27'h3, 27'h0);
        offer(EV_CLEAR, 8'h00, 27'h0, 27'd86399999);
        offer(EV_RELEASE, 8'h00, 27'h0, 27'd1);

        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: setting = 8'h00;
                1: setting = 8'hFF;
                2: setting = 8'h01;
                3: setting = 8'hFE;
                default: setting = 8'($urandom);
            endcase
            write_own_id(setting);
            if (phase == 2 || phase == 6) hold_asked++;
            target = 25 + (phase + 1) * 125;
            while (items_sent < target) run_round();
        end

        wait_drained();
        $display("Sent %0d input transactions under %0d own-id settings; %0d results checked.",
                 items_sent, config_writes, results_seen);
        $display("Covered election, ring markers, token passes, held clears and stray traffic.");
        if (error_count == 0 && results_left == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/retn_pkg.sv
rtl/core/retn_step.sv
rtl/core/retn_outbuf.sv
rtl/core/ring_election_token_node.sv
tb/ring_node_checker.sv
tb/testbench.sv
